// ===== hdl/lr4obs_pkg.sv =====
package lr4obs_pkg;

	// fixed field widths
	localparam int IN_W   = 24;
	localparam int BAND_W = 25;
	localparam int SIG_W  = 28;	// internal Q5.23 signal
	localparam int COEF_W = 33;	// Q3.30 coefficient, sign included
	localparam int ACC_W  = 62;	// Q.53 accumulator, five products
	localparam int FRAC_SH = 30;
	localparam int WIDE_W = ACC_W - FRAC_SH;

	localparam int NUM_BANDS_DEF = 7;
	localparam int MAX_STAGES    = 7;
	localparam int SAMPLE_RATE_HZ = 48000;

	localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-FRAC_SH){1'b0}},
		1'b1, {(FRAC_SH-1){1'b0}}};

	// saturation bounds
	localparam logic signed [WIDE_W-1:0] SIG_HI = {{(WIDE_W-SIG_W+1){1'b0}},
		{(SIG_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] SIG_LO = {{(WIDE_W-SIG_W+1){1'b1}},
		{(SIG_W-1){1'b0}}};
	localparam logic signed [SIG_W-1:0] BAND_HI = {{(SIG_W-BAND_W+1){1'b0}},
		{(BAND_W-1){1'b1}}};
	localparam logic signed [SIG_W-1:0] BAND_LO = {{(SIG_W-BAND_W+1){1'b1}},
		{(BAND_W-1){1'b0}}};

	// shared MAC control
	typedef struct packed {
		logic mul;	// register a product
		logic clr;	// zero the accumulator
		logic add;	// add the registered product
	} mac_ctl_t;

	// per-stage coefficient set, feedback terms stored negated
	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] na1;
		logic signed [COEF_W-1:0] na2;
	} coef_set_t;

	// ---- coefficient design, elaboration only ----
	localparam logic [63:0] ONE_Q60        = 64'h1000_0000_0000_0000;
	localparam logic [63:0] PI_Q60         = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] HALF_SQRT2_Q60 = 64'h0B50_4F33_3F9D_E648;
	localparam logic [63:0] MIN_FC_HZ      = 64'd20;
	localparam int TAYLOR_TERMS = 31;
	localparam logic [63:0] STEP_Q60   = (64'd2 * PI_Q60) / SAMPLE_RATE_HZ;
	localparam logic [63:0] WMAX_Q60   = PI_Q60 / 64'd10 * 64'd9;	// 0.45 of 2*pi
	localparam logic [63:0] W_FC_LIMIT = WMAX_Q60 / STEP_Q60;
	localparam logic [63:0] XOVER_HZ [MAX_STAGES] = '{64'd177, 64'd354, 64'd707,
		64'd1414, 64'd2828, 64'd5657, 64'd11314};

	// (a*b) >> 60 with the full 128-bit product
	function automatic logic [63:0] umul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// restoring long division
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] div_round(input logic [63:0] n, input logic [63:0] d);
		return udiv64(n + (d >> 1), d);
	endfunction

	// Butterworth lowpass, Q = 1/sqrt(2), cut-off of crossover st
	function automatic coef_set_t lr4_coefs(input int st);
		logic [63:0] fc, w, t, sinv, alpha, a0s, omc, cmag, nq;
		logic signed [63:0] s, c;
		coef_set_t r;
		fc = XOVER_HZ[st];
		if (fc < MIN_FC_HZ) fc = MIN_FC_HZ;
		w = (fc > W_FC_LIMIT) ? WMAX_Q60 : STEP_Q60 * fc;
		if (w > WMAX_Q60) w = WMAX_Q60;
		s = '0;
		c = '0;
		t = ONE_Q60;
		for (int k = 0; k < TAYLOR_TERMS; k++) begin
			case (k % 4)
				0: c = c + $signed(t);
				1: s = s + $signed(t);
				2: c = c - $signed(t);
				default: s = s - $signed(t);
			endcase
			t = udiv64(umul_q60(t, w), 64'(k + 1));
		end
		if (c > $signed(ONE_Q60)) c = $signed(ONE_Q60);
		if (c < -$signed(ONE_Q60)) c = -$signed(ONE_Q60);
		sinv = s[63] ? 64'd0 : s;
		alpha = umul_q60(sinv, HALF_SQRT2_Q60);
		if (alpha >= ONE_Q60) alpha = ONE_Q60 - 64'd1;
		a0s = (ONE_Q60 + alpha) >> 30;
		omc = ONE_Q60 - c;
		cmag = c[63] ? -c : c;
		r.b0 = COEF_W'(div_round(omc >> 1, a0s));
		r.b1 = COEF_W'(div_round(omc, a0s));
		nq = div_round(cmag << 1, a0s);
		r.na1 = (c > 0) ? COEF_W'(nq) : -COEF_W'(nq);
		r.na2 = -COEF_W'(div_round(ONE_Q60 - alpha, a0s));
		return r;
	endfunction

	localparam coef_set_t CF_TAB [MAX_STAGES] = '{lr4_coefs(0), lr4_coefs(1),
		lr4_coefs(2), lr4_coefs(3), lr4_coefs(4), lr4_coefs(5), lr4_coefs(6)};

	// ---- saturation ----
	function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [WIDE_W-1:0] v);
		logic signed [SIG_W-1:0] r;
		if (v > SIG_HI) r = SIG_HI[SIG_W-1:0];
		else if (v < SIG_LO) r = SIG_LO[SIG_W-1:0];
		else r = v[SIG_W-1:0];
		return r;
	endfunction

	function automatic logic signed [BAND_W-1:0] sat_band(input logic signed [SIG_W-1:0] v);
		logic signed [BAND_W-1:0] r;
		if (v > BAND_HI) r = BAND_HI[BAND_W-1:0];
		else if (v < BAND_LO) r = BAND_LO[BAND_W-1:0];
		else r = v[BAND_W-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/lr4obs_mac.sv =====
module lr4obs_mac
	import lr4obs_pkg::*;
(
	input  logic                     clk,
	input  mac_ctl_t                 ctl,
	input  logic signed [COEF_W-1:0] coef,
	input  logic signed [SIG_W-1:0]  data,
	output logic signed [SIG_W-1:0]  y
);

	localparam int PROD_W = COEF_W + SIG_W;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_rnd;

	// product registered, added in the following cycle
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= coef * data;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// round half up at bit 30, floor, then clamp to Q5.23
	assign acc_rnd = acc_q + RND_HALF;
	assign y = sat_sig(acc_rnd[ACC_W-1:FRAC_SH]);

endmodule

// ===== hdl/lr4_octave_band_splitter_unit.sv =====
// Linkwitz-Riley LR4 octave band splitter. Each input transaction carries one
// signed Q1.23 sample; each output transaction carries NUM_BANDS saturated
// 25-bit bands, lowest band in the lowest bits of m_tdata. NUM_BANDS-1
// crossovers (177 Hz upwards in octaves, coefficients fixed at build time
// for the package sample rate) are chained: each runs two identical
// Butterworth biquads on the running remainder, the result is one band and
// the remainder minus that band moves on; the last remainder is the top
// band. All twelve biquads (default build) share one 33x28 multiplier and
// one accumulator, with five product phases per biquad plus a drain phase
// and a write-back phase. s_tready is low from acceptance of a sample until
// its bands have been loaded into the output register, so the block does
// not take a new sample before it is through with the last one. The
// finished result sits in the output register, so the next sample is taken
// as soon as the previous one has been loaded there. Filter history lives
// in an 8*(NUM_BANDS-1) word memory with one read and one write per cycle;
// per-word valid flags make it read as zero after reset, so no clearing
// pass is needed and the block is ready as soon as reset is released.
module lr4_octave_band_splitter_unit
	import lr4obs_pkg::*;
#(
	parameter int NUM_BANDS = NUM_BANDS_DEF,
	localparam int M_TDATA_W = ((NUM_BANDS * BAND_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,	// [23:0] sample_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata	// band_0 at [24:0], band_1 next, ... zero pad
);

	localparam int NSTAGE     = NUM_BANDS - 1;
	localparam int STG_W      = (NSTAGE > 1) ? $clog2(NSTAGE) : 1;
	localparam int HIST_DEPTH = NSTAGE * 8;
	localparam int AW         = $clog2(HIST_DEPTH);
	localparam int PACK_W     = NUM_BANDS * BAND_W;

	// sequencer phases within one biquad
	localparam logic [2:0] PH_0 = 3'd0;	// b0*x, read x1
	localparam logic [2:0] PH_1 = 3'd1;	// b1*x1, read x2, store x1 <= x
	localparam logic [2:0] PH_2 = 3'd2;	// b2*x2, read y1, store x2 <= x1
	localparam logic [2:0] PH_3 = 3'd3;	// -a1*y1, read y2
	localparam logic [2:0] PH_4 = 3'd4;	// -a2*y2, store y2 <= y1
	localparam logic [2:0] PH_5 = 3'd5;	// drain last product
	localparam logic [2:0] PH_6 = 3'd6;	// write back y1 <= y, advance

	// word order within a biquad's four history words
	localparam logic [1:0] HI_X1 = 2'd0;
	localparam logic [1:0] HI_X2 = 2'd1;
	localparam logic [1:0] HI_Y1 = 2'd2;
	localparam logic [1:0] HI_Y2 = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [STG_W-1:0]         stage_q;
	logic                     sec_q;	// 0: first biquad, 1: second
	logic [2:0]               ph_q;
	logic signed [SIG_W-1:0]  x_q;	// input of the biquad in progress
	logic signed [SIG_W-1:0]  rem_q;	// running remainder
	logic signed [SIG_W-1:0]  x1_q;
	logic signed [SIG_W-1:0]  y1_q;
	logic signed [BAND_W-1:0] bands_q [NUM_BANDS];
	logic [PACK_W-1:0]        out_pack;

	// history memory
	logic signed [SIG_W-1:0]  hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0]    hvld_q;
	logic signed [SIG_W-1:0]  rd_data_q;
	logic                     rd_vld_q;
	logic signed [SIG_W-1:0]  hist_rd;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic [1:0]               wr_idx;
	logic                     wr_en;
	logic signed [SIG_W-1:0]  wr_data;

	// MAC
	mac_ctl_t                 mac_ctl;
	coef_set_t                cset;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [SIG_W-1:0]  mac_data;
	logic signed [SIG_W-1:0]  mac_y;
	logic signed [SIG_W-1:0]  rem_nxt;

	assign s_tready = (state_q == ST_IDLE);

	// coefficients of the current stage
	always_comb begin
		cset = CF_TAB[0];
		for (int i = 1; i < NSTAGE; i++) begin
			if (stage_q == STG_W'(i)) begin
				cset = CF_TAB[i];
			end
		end
	end

	// unwritten history words read as zero
	assign hist_rd = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		mac_ctl.mul = (state_q == ST_RUN) && (ph_q <= PH_4);
		mac_ctl.clr = (state_q == ST_RUN) && (ph_q == PH_0);
		mac_ctl.add = (state_q == ST_RUN) && (ph_q != PH_0) && (ph_q <= PH_5);
		mac_data = (ph_q == PH_0) ? x_q : hist_rd;
		unique case (ph_q)
			PH_0:    mac_coef = cset.b0;
			PH_1:    mac_coef = cset.b1;
			PH_2:    mac_coef = cset.b0;	// b2 equals b0
			PH_3:    mac_coef = cset.na1;
			PH_4:    mac_coef = cset.na2;
			default: mac_coef = '0;
		endcase
	end

	lr4obs_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.coef (mac_coef),
		.data (mac_data),
		.y    (mac_y)
	);

	assign rem_nxt = sat_sig(WIDE_W'(rem_q) - WIDE_W'(mac_y));

	// history port schedule: each read is registered and issued in the phase before its multiply
	assign rd_addr = AW'({stage_q, sec_q, ph_q[1:0]});

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = HI_X1;
		wr_data = x_q;
		if (state_q == ST_RUN) begin
			unique case (ph_q)
				PH_1: begin
					wr_en   = 1'b1;
					wr_idx  = HI_X1;
					wr_data = x_q;
				end
				PH_2: begin
					wr_en   = 1'b1;
					wr_idx  = HI_X2;
					wr_data = x1_q;
				end
				PH_4: begin
					wr_en   = 1'b1;
					wr_idx  = HI_Y2;
					wr_data = y1_q;
				end
				PH_6: begin
					wr_en   = 1'b1;
					wr_idx  = HI_Y1;
					wr_data = mac_y;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	assign wr_addr = AW'({stage_q, sec_q, wr_idx});

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= hist_mem[rd_addr];
		rd_vld_q  <= hvld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvld_q <= '0;
		end else if (wr_en) begin
			hvld_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		out_pack = '0;
		for (int b = 0; b < NUM_BANDS; b++) begin
			out_pack[b*BAND_W +: BAND_W] = bands_q[b];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			stage_q  <= '0;
			sec_q    <= 1'b0;
			ph_q     <= PH_0;
			x_q      <= '0;
			rem_q    <= '0;
			x1_q     <= '0;
			y1_q     <= '0;
			bands_q  <= '{default: '0};
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			// in ST_DONE the reload below decides m_tvalid
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= SIG_W'(signed'(s_tdata));
						rem_q   <= SIG_W'(signed'(s_tdata));
						stage_q <= '0;
						sec_q   <= 1'b0;
						ph_q    <= PH_0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (ph_q == PH_1) begin
						x1_q <= hist_rd;
					end
					if (ph_q == PH_3) begin
						y1_q <= hist_rd;
					end
					if (ph_q != PH_6) begin
						ph_q <= ph_q + 3'd1;
					end else begin
						ph_q <= PH_0;
						if (!sec_q) begin
							// second biquad filters the first one's output
							x_q   <= mac_y;
							sec_q <= 1'b1;
						end else begin
							sec_q <= 1'b0;
							rem_q <= rem_nxt;
							x_q   <= rem_nxt;
							for (int b = 0; b < NSTAGE; b++) begin
								if (stage_q == STG_W'(b)) begin
									bands_q[b] <= sat_band(mac_y);
								end
							end
							if (stage_q == STG_W'(NSTAGE - 1)) begin
								bands_q[NSTAGE] <= sat_band(rem_nxt);
								state_q <= ST_DONE;
							end else begin
								stage_q <= stage_q + 1'b1;
							end
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= M_TDATA_W'(out_pack);
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- checks ----
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_RUN && stage_q == '0 && ph_q == PH_0 && !sec_q)
		else $error("sequencer did not start from the first stage");

	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> ph_q <= PH_6 && stage_q <= STG_W'(NSTAGE - 1))
		else $error("phase or stage counter out of range");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> {1'b0, wr_addr} < (AW + 1)'(HIST_DEPTH))
		else $error("history write beyond memory");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result presented without a finished sample");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import lr4obs_pkg::IN_W;
	import lr4obs_pkg::BAND_W;
	import lr4obs_pkg::NUM_BANDS_DEF;
	import lr4obs_pkg::SAMPLE_RATE_HZ;

	localparam int NSTAGE  = NUM_BANDS_DEF - 1;
	localparam int TDATA_W = ((NUM_BANDS_DEF * BAND_W + 7) / 8) * 8;
	localparam int PAD_LO  = NUM_BANDS_DEF * BAND_W;

	// coefficient design, unsigned Q4.60
	localparam longint unsigned Q60_ONE      = 64'h1000_0000_0000_0000;
	localparam longint unsigned Q60_PI       = 64'h3243_F6A8_885A_308D;
	localparam longint unsigned Q60_HALF_RT2 = 64'h0B50_4F33_3F9D_E648;
	localparam longint unsigned MIN_FC       = 64'd20;
	localparam int SERIES_LEN = 31;

	// internal Q5.23 signal range and 25-bit band range
	localparam longint INT_HI  = 64'sh7FF_FFFF;
	localparam longint INT_LO  = -64'sh800_0000;
	localparam longint BAND_HI = 64'shFF_FFFF;
	localparam longint BAND_LO = -64'sh100_0000;
	localparam longint ROUND_HALF = 64'sd536870912;	// 2^29, half an LSB after >>30

	localparam logic [IN_W-1:0] SMP_MAX = 24'h7F_FFFF;
	localparam logic [IN_W-1:0] SMP_MIN = 24'h80_0000;

	localparam int MAX_PRINTS = 40;

	// ---------------------------------------------------------------- DUT
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;	// [23:0] sample_in
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;		// band_0 [24:0], band_1 [49:25], ... zero pad on top

	lr4_octave_band_splitter_unit #(
		.NUM_BANDS(NUM_BANDS_DEF)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------- predictor
	// Own copy of the crossover coefficients (Q3.30) and filter history.
	longint xo_b0 [NSTAGE];
	longint xo_b1 [NSTAGE];
	longint xo_a1 [NSTAGE];
	longint xo_a2 [NSTAGE];
	// per stage: x1, x2, y1, y2 of the first section, then of the second
	longint lp_hist [NSTAGE][8];

	// expected band sets, oldest first, packed as m_tdata should look
	logic [TDATA_W-1:0] band_sets_due [$];

	int err_count     = 0;
	int samples_sent  = 0;
	int results_seen  = 0;
	int int_sat_hits  = 0;
	int band_sat_hits = 0;

	// idling controls for sender and receiver
	bit tx_idle_en  = 1'b1;
	bit rx_idle_en  = 1'b1;
	int rx_hold_req = 0;
	int hold_left   = 0;
	int stall_left  = 0;

	function automatic longint unsigned xover_hz(input int st);
		case (st)
			0: return 64'd177;
			1: return 64'd354;
			2: return 64'd707;
			3: return 64'd1414;
			4: return 64'd2828;
			5: return 64'd5657;
			default: return 64'd11314;
		endcase
	endfunction

	// exact 128-bit product, back to Q60
	function automatic longint unsigned mul_q60(input longint unsigned a,
		input longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> 60);
	endfunction

	function automatic longint unsigned round_div(input longint unsigned num,
		input longint unsigned den);
		return (num + den / 2) / den;
	endfunction

	// Butterworth lowpass (Q = 1/sqrt 2) per crossover; sin/cos by Taylor series
	function automatic void design_crossovers();
		longint unsigned w_step, wmax, w, fc, t, sinv, alpha, a0s, omc, cmag;
		longint s, c;
		w_step = (64'd2 * Q60_PI) / 64'(SAMPLE_RATE_HZ);
		if (w_step == 0)
			w_step = 1;
		wmax = Q60_PI / 10 * 9;
		for (int st = 0; st < NSTAGE; st++) begin
			fc = xover_hz(st);
			if (fc < MIN_FC)
				fc = MIN_FC;
			w = (fc > wmax / w_step) ? wmax : w_step * fc;
			if (w > wmax)
				w = wmax;
			s = 0;
			c = 0;
			t = Q60_ONE;
			for (int k = 0; k < SERIES_LEN; k++) begin
				case (k % 4)
					0: c = c + $signed(t);
					1: s = s + $signed(t);
					2: c = c - $signed(t);
					default: s = s - $signed(t);
				endcase
				t = mul_q60(t, w) / 64'(k + 1);
			end
			if (c > $signed(Q60_ONE))
				c = $signed(Q60_ONE);
			if (c < -$signed(Q60_ONE))
				c = -$signed(Q60_ONE);
			sinv = (s < 0) ? 64'd0 : s;
			alpha = mul_q60(sinv, Q60_HALF_RT2);
			if (alpha >= Q60_ONE)
				alpha = Q60_ONE - 1;
			a0s = (Q60_ONE + alpha) >> 30;
			omc = $signed(Q60_ONE) - c;
			cmag = (c < 0) ? -c : c;
			xo_b0[st] = $signed(round_div(omc >> 1, a0s));
			xo_b1[st] = $signed(round_div(omc, a0s));
			xo_a1[st] = (c > 0) ? -$signed(round_div(cmag << 1, a0s))
				: $signed(round_div(cmag << 1, a0s));
			xo_a2[st] = $signed(round_div(Q60_ONE - alpha, a0s));
			for (int i = 0; i < 8; i++)
				lp_hist[st][i] = 0;
		end
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one biquad section; base picks the first (0) or second (4) history set
	function automatic longint lp_section(input int st, input int base, input longint x);
		longint acc, y;
		acc = xo_b0[st] * x + xo_b1[st] * lp_hist[st][base]
			+ xo_b0[st] * lp_hist[st][base + 1]
			- xo_a1[st] * lp_hist[st][base + 2] - xo_a2[st] * lp_hist[st][base + 3];
		y = (acc + ROUND_HALF) >>> 30;
		if (y > INT_HI || y < INT_LO)
			int_sat_hits++;
		y = clamp(y, INT_LO, INT_HI);
		lp_hist[st][base + 1] = lp_hist[st][base];
		lp_hist[st][base]     = x;
		lp_hist[st][base + 3] = lp_hist[st][base + 2];
		lp_hist[st][base + 2] = y;
		return y;
	endfunction

	function automatic logic [BAND_W-1:0] to_band(input longint v);
		if (v > BAND_HI || v < BAND_LO)
			band_sat_hits++;
		return BAND_W'(clamp(v, BAND_LO, BAND_HI));
	endfunction

	// advance the filter bank by one sample, return the band set it gives
	function automatic logic [TDATA_W-1:0] split_into_bands(input logic [IN_W-1:0] smp);
		logic [TDATA_W-1:0] word;
		longint rest, band;
		word = '0;
		rest = longint'($signed(smp));
		for (int st = 0; st < NSTAGE; st++) begin
			band = lp_section(st, 0, rest);
			band = lp_section(st, 4, band);
			word[st * BAND_W +: BAND_W] = to_band(band);
			// remainder is taken from the band before output saturation
			rest = clamp(rest - band, INT_LO, INT_HI);
		end
		word[NSTAGE * BAND_W +: BAND_W] = to_band(rest);
		return word;
	endfunction

	// ------------------------------------------------------------ helpers
	task automatic report_mismatch(input string what);
		if (err_count < MAX_PRINTS)
			$display("%0t MISMATCH: %s", $realtime, what);
		err_count++;
	endtask

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 150);
	endfunction

	// offer one sample; returns at the edge where the transaction happens
	task automatic send_sample(input logic [IN_W-1:0] smp);
		int gap;
		gap = tx_idle_en ? idle_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_W'($urandom);	// junk while idle
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		band_sets_due.push_back(split_into_bands(smp));
		samples_sent++;
	endtask

	// sender goes quiet until every outstanding band set has been checked
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (band_sets_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------- result side/checker
	// m_tready: long hold-off on request, else random stalls when enabled.
	always @(posedge clk) begin : result_side
		logic [TDATA_W-1:0] due;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (band_sets_due.size() == 0) begin
					report_mismatch($sformatf("band set with no sample pending, m_tdata=%h",
						m_tdata));
				end else begin
					due = band_sets_due.pop_front();
					for (int b = 0; b < NUM_BANDS_DEF; b++) begin
						if (m_tdata[b * BAND_W +: BAND_W] !== due[b * BAND_W +: BAND_W])
							report_mismatch($sformatf("result %0d band_%0d: got %0d, want %0d",
								results_seen, b, $signed(m_tdata[b * BAND_W +: BAND_W]),
								$signed(due[b * BAND_W +: BAND_W])));
					end
					if ((m_tdata >> PAD_LO) !== (due >> PAD_LO))
						report_mismatch($sformatf("result %0d: pad bits not zero (%h)",
							results_seen, m_tdata >> PAD_LO));
				end
			end
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = rx_idle_en ? idle_gap() : 0;
			end
		end
	end

	// --------------------------------------------------------------- tests
	// full-scale values, single-bit toggles, steps and Nyquist alternation
	task automatic test_directed_extremes();
		logic [IN_W-1:0] pts [$];
		pts = '{24'h00_0000, 24'h00_0001, 24'hFF_FFFF, 24'h55_5555, 24'hAA_AAAA};
		repeat (4) pts.push_back(SMP_MAX);
		repeat (4) pts.push_back(SMP_MIN);
		repeat (3) begin
			pts.push_back(SMP_MAX);
			pts.push_back(SMP_MIN);
		end
		repeat (2) pts.push_back(24'h00_0000);
		foreach (pts[i])
			send_sample(pts[i]);
	endtask

	// square bursts: big steps push remainders past the internal range
	task automatic test_square_bursts(input int n_items);
		int to_go, period, burst;
		logic [IN_W-1:0] hi_lvl, lo_lvl;
		to_go = n_items;
		while (to_go > 0) begin
			period = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 300)
				: $urandom_range(1, 32);
			if ($urandom_range(0, 1)) begin
				hi_lvl = SMP_MAX;
				lo_lvl = SMP_MIN;
			end else begin
				hi_lvl = IN_W'($urandom);
				lo_lvl = IN_W'($urandom);
			end
			burst = $urandom_range(8, 120);
			for (int k = 0; k < burst && to_go > 0; k++) begin
				send_sample(((k / period) % 2) ? lo_lvl : hi_lvl);
				to_go--;
			end
		end
	endtask

	// white noise over the whole range, mixed with quiet low-level samples
	task automatic test_noise(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_sample(IN_W'($signed($urandom_range(0, 63)) - 32));
			else
				send_sample(IN_W'($urandom));
		end
	endtask

	// no idling either side; random walk so the low bands carry real signal
	task automatic test_back_to_back(input int n_items);
		longint lvl;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		lvl = 0;
		for (int i = 0; i < n_items; i++) begin
			lvl = clamp(lvl + $signed($urandom_range(0, 2097151)) - 1048576,
				$signed(SMP_MIN), $signed(SMP_MAX));
			send_sample(IN_W'(lvl));
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// receiver holds off long enough for the output register to fill and
	// s_tready to stay low while the sender keeps offering
	task automatic test_output_stall();
		rx_hold_req = 800;
		tx_idle_en = 1'b0;
		repeat (12) send_sample(IN_W'($urandom));
		tx_idle_en = 1'b1;
	endtask

	// sender drains completely mid-stream, then carries on
	task automatic test_drain_pause();
		repeat (40) send_sample(IN_W'($urandom));
		wait_drained();
		test_square_bursts(40);
	endtask

	// ---------------------------------------------------------------- main
	initial begin : main_seq
		int spin;
		design_crossovers();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_square_bursts(500);
		test_noise(420);
		test_output_stall();
		test_back_to_back(200);
		test_drain_pause();

		// allow for the last sample plus receiver stalls
		s_tvalid <= 1'b0;
		spin = 0;
		while (band_sets_due.size() != 0 && spin < 20000) begin
			@(posedge clk);
			spin++;
		end
		repeat (200) @(posedge clk);
		if (band_sets_due.size() != 0)
			report_mismatch($sformatf("%0d band sets never arrived", band_sets_due.size()));

		$display("Covered %0d samples, %0d band sets: extremes, square bursts, noise,",
			samples_sent, results_seen);
		$display("  back-to-back, output hold-off, drain pause; saturation %0d internal, %0d out",
			int_sat_hits, band_sat_hits);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Slowest correct run: ~1250 samples, each with its processing, the longest
	// sender gap and receiver stall, plus the long hold-off, is about 1 ms; allow five times that.
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== lr4_octave_band_splitter_unit.f =====
hdl/lr4obs_pkg.sv
hdl/lr4obs_mac.sv
hdl/lr4_octave_band_splitter_unit.sv
tb/sv/tb.sv
